>>> design/toe_pkg.sv
`timescale 1ns / 1ps
package toe_pkg;
  localparam int MaxNodes = 32;
  localparam int MaxEdges = 256;
  localparam int NodeW = 5;
  localparam int EdgeAw = 8;
  localparam int EdgeCntW = 9;
  localparam int DegW = 9;
  localparam int CntW = 6;

  localparam logic [2:0] ST_ACCEPT = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_ORDER  = 3'd2;
  localparam logic [2:0] ST_CYCLE  = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic add_edge;     // store edge, bump in-degree
    logic seed_clear;   // reset fifo/placed counters, seed index
    logic seed_step;    // test in-degree of seed index
    logic pop;          // pop fifo head, start edge scan
    logic scan_issue;   // issue edge read at scan index
    logic scan_use;     // consume edge read data
    logic clear_graph;  // drop edges, start degree clear
    logic clear_step;   // zero one in-degree entry
    logic emit_load;    // load order read for emit index
    logic emit_step;    // advance emit index
  } toe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seed_done;
    logic fifo_empty;
    logic scan_done;
    logic clear_done;
    logic all_placed;
    logic emit_last;
  } toe_stat_t;
endpackage

>>> design/toe_ram.sv
`timescale 1ns / 1ps
module toe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write one entry, read registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/toe_datapath.sv
`timescale 1ns / 1ps
module toe_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  toe_pkg::toe_cmd_t          cmd,
  output toe_pkg::toe_stat_t         stat,
  input  logic [5:0]                 node_count,
  input  logic [4:0]                 src_node,
  input  logic [4:0]                 dst_node,
  output logic                       edge_ok,
  output logic [4:0]                 emit_node
);
  import toe_pkg::*;

  logic [CntW-1:0]     n_eff;
  logic [EdgeCntW-1:0] edges_held;
  logic [DegW-1:0]     deg [MaxNodes];
  logic [CntW-1:0]     fifo_head, fifo_tail, placed_count;
  logic [CntW-1:0]     seed_idx, clr_idx, emit_idx;
  logic [EdgeCntW-1:0] scan_idx;
  logic [NodeW-1:0]    cur;
  logic [NodeW-1:0]    fifo_rdata, es_rdata, ed_rdata, ord_rdata;
  logic                push_en;
  logic [NodeW-1:0]    push_node;
  logic [NodeW-1:0]    dd;
  logic [DegW-1:0]     dd_deg;

  assign n_eff = (node_count > 6'(MaxNodes)) ? 6'(MaxNodes) : node_count;
  assign edge_ok = ({1'b0, src_node} < n_eff) && ({1'b0, dst_node} < n_eff)
                   && (edges_held < EdgeCntW'(MaxEdges));

  assign dd = ed_rdata;
  assign dd_deg = deg[dd];

  // decide fifo push from seeding or from a scanned edge
  always_comb begin
    push_en = 1'b0;
    push_node = seed_idx[NodeW-1:0];
    if (cmd.seed_step) begin
      push_en = deg[seed_idx[NodeW-1:0]] == '0;
    end else if (cmd.scan_use && es_rdata == cur && dd_deg != '0) begin
      push_en = (dd_deg == DegW'(1)) && ({1'b0, dd} < n_eff);
      push_node = dd;
    end
    if (fifo_tail >= 6'(MaxNodes)) push_en = 1'b0;
  end

  toe_ram #(.Width(NodeW), .Depth(MaxEdges)) u_src (
    .clk, .we(cmd.add_edge), .waddr(edges_held[EdgeAw-1:0]), .wdata(src_node),
    .raddr(scan_idx[EdgeAw-1:0]), .rdata(es_rdata));
  toe_ram #(.Width(NodeW), .Depth(MaxEdges)) u_dst (
    .clk, .we(cmd.add_edge), .waddr(edges_held[EdgeAw-1:0]), .wdata(dst_node),
    .raddr(scan_idx[EdgeAw-1:0]), .rdata(ed_rdata));
  toe_ram #(.Width(NodeW), .Depth(MaxNodes)) u_fifo (
    .clk, .we(push_en), .waddr(fifo_tail[NodeW-1:0]), .wdata(push_node),
    .raddr(fifo_head[NodeW-1:0]), .rdata(fifo_rdata));
  toe_ram #(.Width(NodeW), .Depth(MaxNodes)) u_ord (
    .clk, .we(cmd.pop && placed_count < 6'(MaxNodes)),
    .waddr(placed_count[NodeW-1:0]), .wdata(fifo_rdata),
    .raddr(emit_idx[NodeW-1:0]), .rdata(ord_rdata));

  // advance counters and in-degrees
  always_ff @(posedge clk) begin
    if (rst) begin
      edges_held <= '0;
      fifo_head <= '0;
      fifo_tail <= '0;
      placed_count <= '0;
      seed_idx <= '0;
      clr_idx <= '0;
      emit_idx <= '0;
      scan_idx <= '0;
      for (int i = 0; i < MaxNodes; i++) deg[i] <= '0;
    end else begin
      if (cmd.add_edge) begin
        edges_held <= edges_held + 1'b1;
        deg[dst_node] <= deg[dst_node] + 1'b1;
      end
      if (cmd.seed_clear) begin
        fifo_head <= '0;
        fifo_tail <= '0;
        placed_count <= '0;
        seed_idx <= '0;
        emit_idx <= '0;
      end
      if (cmd.seed_step) seed_idx <= seed_idx + 1'b1;
      if (push_en) fifo_tail <= fifo_tail + 1'b1;
      if (cmd.pop) begin
        cur <= fifo_rdata;
        fifo_head <= fifo_head + 1'b1;
        if (placed_count < 6'(MaxNodes)) placed_count <= placed_count + 1'b1;
        scan_idx <= '0;
      end
      if (cmd.scan_issue) scan_idx <= scan_idx + 1'b1;
      if (cmd.scan_use && es_rdata == cur && dd_deg != '0) begin
        deg[dd] <= dd_deg - 1'b1;
      end
      if (cmd.clear_graph) begin
        edges_held <= '0;
        clr_idx <= '0;
      end
      if (cmd.clear_step) begin
        deg[clr_idx[NodeW-1:0]] <= '0;
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.emit_step) emit_idx <= emit_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) emit_node <= ord_rdata;
  end

  assign stat.seed_done  = seed_idx >= n_eff;
  assign stat.fifo_empty = fifo_head >= fifo_tail;
  assign stat.scan_done  = scan_idx >= edges_held;
  assign stat.clear_done = clr_idx == 6'(MaxNodes);
  assign stat.all_placed = placed_count == n_eff;
  assign stat.emit_last  = emit_idx + 1'b1 == placed_count;
endmodule

>>> design/toe_ctrl.sv
`timescale 1ns / 1ps
module toe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic               edge_ok,
  input  logic [5:0]         node_count,
  output toe_pkg::toe_cmd_t  cmd,
  input  toe_pkg::toe_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic               is_last,
  output logic               emit_sel
);
  import toe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_POPCHK, S_POPRD, S_SCAN, S_SCANW, S_CLEAR,
    S_RESULT, S_EMITRD, S_EMIT, S_EMITW
  } state_t;

  state_t state;
  logic   first;
  logic   scan_pend;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // decode commands from state
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.add_edge = in_valid && in_ready && req_type == REQ_EDGE && edge_ok;
        cmd.seed_clear = in_valid && in_ready && req_type == REQ_RUN;
      end
      S_SEED:   cmd.seed_step = !stat.seed_done;
      S_POPRD:  cmd.pop = 1'b1;
      S_SCAN: begin
        cmd.scan_issue = !stat.scan_done;
        cmd.scan_use = scan_pend;
      end
      S_SCANW:  cmd.scan_use = scan_pend;
      S_CLEAR:  cmd.clear_step = first ? 1'b0 : !stat.clear_done;
      S_EMITRD: cmd.emit_load = 1'b1;
      // node already loaded, so advance the read index for the next beat
      S_EMIT:   cmd.emit_step = !stat.emit_last;
      default:  cmd = '0;
    endcase
    if (state == S_CLEAR && first) cmd.clear_graph = 1'b1;
  end

  // hold state and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      status <= ST_ACCEPT;
      is_last <= 1'b0;
      emit_sel <= 1'b0;
      first <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && state == S_IDLE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (req_type == REQ_EDGE) begin
              out_valid <= 1'b1;
              status <= edge_ok ? ST_ACCEPT : ST_REJECT;
              is_last <= 1'b1;
              emit_sel <= 1'b0;
            end else if (node_count == '0) begin
              state <= S_CLEAR;
              first <= 1'b1;
            end else begin
              state <= S_SEED;
            end
          end
        end
        S_SEED: if (stat.seed_done) state <= S_POPCHK;
        S_POPCHK: begin
          if (stat.fifo_empty) begin
            state <= S_CLEAR;
            first <= 1'b1;
          end else begin
            state <= S_POPRD;
          end
        end
        S_POPRD: begin
          state <= S_SCAN;
          scan_pend <= 1'b0;
        end
        S_SCAN: begin
          scan_pend <= !stat.scan_done;
          if (stat.scan_done) state <= S_SCANW;
        end
        S_SCANW: begin
          scan_pend <= 1'b0;
          state <= S_POPCHK;
        end
        S_CLEAR: begin
          first <= 1'b0;
          if (!first && stat.clear_done) begin
            if (node_count == '0) begin
              state <= S_RESULT;
              status <= ST_EMPTY;
            end else if (!stat.all_placed) begin
              state <= S_RESULT;
              status <= ST_CYCLE;
            end else begin
              state <= S_EMITRD;
            end
          end
        end
        S_RESULT: begin
          out_valid <= 1'b1;
          is_last <= 1'b1;
          emit_sel <= 1'b0;
          state <= S_IDLE;
        end
        S_EMITRD: state <= S_EMIT;
        S_EMIT: begin
          out_valid <= 1'b1;
          status <= ST_ORDER;
          emit_sel <= 1'b1;
          is_last <= stat.emit_last;
          state <= S_EMITW;
        end
        S_EMITW: begin
          if (out_ready) begin
            if (is_last) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end else begin
              out_valid <= 1'b0;
              state <= S_EMITRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/topological_order_engine_core.sv
`timescale 1ns / 1ps
// Kahn topological sort engine.
// Input channel (in_valid/in_ready): req_type 0 stores edge src_node->dst_node
// and returns one beat, status accepted or rejected.
// req_type 1 runs the sort: nodes of zero in-degree are seeded in index order,
// then each popped node scans the whole edge table, one edge per cycle through
// the edge memory read port, and the in-degree table is cleared at the end.
// The result is the order as a burst of beats (status order entry, is_last on
// the final one), or one cycle-found beat, or one empty beat.
// Config channel (cfg_valid/cfg_ready) writes node_count; write only when idle.
// Input is held off (in_ready low) during a run and while a result waits.
// A stalled receiver holds the current beat; the engine waits with it.
// Reset (rst, synchronous) clears node_count, edge count and in-degrees.
// Each order beat passes through a memory read, a load and a hand off.
module topological_order_engine_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] node_count,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [4:0] src_node,
  input  logic [4:0] dst_node,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [4:0] node_index,
  output logic       is_last
);
  import toe_pkg::*;

  logic [5:0] node_count_q;
  toe_cmd_t   cmd;
  toe_stat_t  stat;
  logic       edge_ok;
  logic [4:0] emit_node;
  logic       emit_sel;

  assign cfg_ready = 1'b1;

  // hold node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count_q <= '0;
    end else if (cfg_valid) begin
      node_count_q <= node_count;
    end
  end

  toe_datapath u_dp (
    .clk, .rst, .cmd, .stat, .node_count(node_count_q),
    .src_node, .dst_node, .edge_ok, .emit_node);

  toe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type, .edge_ok,
    .node_count(node_count_q), .cmd, .stat, .out_valid, .out_ready,
    .status, .is_last, .emit_sel);

  assign node_index = emit_sel ? emit_node : '0;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_edge_one_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_EDGE) |=> out_valid && is_last)
    else $error("edge result missing");
  a_order_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ORDER) |-> node_index == '0)
    else $error("index on non-order beat");
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import toe_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] node_count;
  logic       in_valid;
  logic       in_ready;
  logic       req_type;
  logic [4:0] src_node;
  logic [4:0] dst_node;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [4:0] node_index;
  logic       is_last;

  topological_order_engine_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .node_count(node_count),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .src_node(src_node), .dst_node(dst_node),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .node_index(node_index), .is_last(is_last)
  );

  typedef struct packed {
    logic [2:0] st;
    logic [4:0] node;
    logic       last;
  } sort_beat_t;

  // predictor copy of the engine state
  int unsigned nodes_cfg;
  int unsigned edge_src_q[$];
  int unsigned edge_dst_q[$];
  int unsigned indeg[MaxNodes];
  sort_beat_t  expected_beats[$];

  int errors;
  int mismatches;
  int idle_cycles;
  int run_beats_seen;
  bit hold_rx;
  bit rx_random;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_graph();
    edge_src_q.delete();
    edge_dst_q.delete();
    for (int i = 0; i < MaxNodes; i++) indeg[i] = 0;
  endfunction

  // append one expected beat
  function automatic void add_expected(logic [2:0] st, logic [4:0] node, logic last);
    sort_beat_t b;
    b.st = st;
    b.node = node;
    b.last = last;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // compute expected beats for one accepted item
  function automatic void predict_sort(bit rq, int unsigned s, int unsigned d);
    int unsigned n;
    int unsigned fifo[$];
    int unsigned order[$];
    int unsigned cur;
    n = (nodes_cfg > MaxNodes) ? MaxNodes : nodes_cfg;
    if (rq == REQ_EDGE) begin
      if (s >= n || d >= n || edge_src_q.size() >= MaxEdges) begin
        add_expected(ST_REJECT, 5'd0, 1'b1);
      end else begin
        edge_src_q.insert(edge_src_q.size(), s);
        edge_dst_q.insert(edge_dst_q.size(), d);
        indeg[d]++;
        add_expected(ST_ACCEPT, 5'd0, 1'b1);
      end
      return;
    end
    if (n == 0) begin
      clear_graph();
      add_expected(ST_EMPTY, 5'd0, 1'b1);
      return;
    end
    for (int unsigned i = 0; i < n; i++)
      if (indeg[i] == 0) fifo.insert(fifo.size(), i);
    while (fifo.size() > 0) begin
      cur = fifo.pop_front();
      order.insert(order.size(), cur);
      foreach (edge_src_q[e]) begin
        if (edge_src_q[e] == cur && indeg[edge_dst_q[e]] != 0) begin
          indeg[edge_dst_q[e]]--;
          if (indeg[edge_dst_q[e]] == 0 && edge_dst_q[e] < n)
            fifo.insert(fifo.size(), edge_dst_q[e]);
        end
      end
    end
    clear_graph();
    if (order.size() != n) begin
      add_expected(ST_CYCLE, 5'd0, 1'b1);
    end else begin
      foreach (order[k])
        add_expected(ST_ORDER, order[k][4:0], k == order.size() - 1);
    end
  endfunction

  // send one item, optional random gap before it
  task automatic send_req(bit rq, int unsigned s, int unsigned d, bit gaps = 1);
    if (gaps) repeat ($urandom_range(0, 11)) @(negedge clk);
    in_valid = 1'b1;
    req_type = rq;
    src_node = s[4:0];
    dst_node = d[4:0];
    do @(posedge clk); while (!in_ready);
    predict_sort(rq, s, d);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_beats.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_nodes(int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    node_count <= v[5:0];
    do @(posedge clk); while (!cfg_ready);
    nodes_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // build a random graph over the first n nodes, optionally with a loop, then run
  task automatic dag_and_run(int unsigned n, int unsigned edges, bit make_loop);
    int unsigned a;
    int unsigned b;
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if (a > b) send_req(REQ_EDGE, b, a);
      else if (a < b) send_req(REQ_EDGE, a, b);
      else send_req(REQ_EDGE, a, (a + 1) % n);
    end
    if (make_loop && n > 1) begin
      send_req(REQ_EDGE, 0, 1);
      send_req(REQ_EDGE, 1, 0);
    end
    send_req(REQ_RUN, $urandom_range(0, 31), $urandom_range(0, 31));
  endtask

  task automatic test_directed();
    write_nodes(0);
    send_req(REQ_EDGE, 0, 0);
    send_req(REQ_RUN, 31, 31);
    write_nodes(32);
    send_req(REQ_EDGE, 31, 0);
    send_req(REQ_EDGE, 0, 31);
    send_req(REQ_EDGE, 31, 0);
    send_req(REQ_RUN, 0, 0);
    send_req(REQ_EDGE, 3, 5);
    send_req(REQ_EDGE, 3, 5);
    send_req(REQ_EDGE, 5, 7);
    send_req(REQ_RUN, 21, 10);
    write_nodes(63);
    send_req(REQ_EDGE, 31, 31);
    send_req(REQ_RUN, 0, 0);
    write_nodes(4);
    send_req(REQ_EDGE, 4, 1);
    send_req(REQ_EDGE, 1, 4);
    send_req(REQ_EDGE, 2, 3);
    send_req(REQ_RUN, 0, 0);
  endtask

  // node count lowered below stored edges
  task automatic test_lowered_count();
    write_nodes(6);
    send_req(REQ_EDGE, 5, 1);
    send_req(REQ_EDGE, 0, 4);
    send_req(REQ_EDGE, 2, 3);
    write_nodes(4);
    send_req(REQ_RUN, 0, 0);
    write_nodes(6);
    send_req(REQ_EDGE, 0, 5);
    write_nodes(5);
    send_req(REQ_RUN, 0, 0);
  endtask

  // fill the edge table to reject overflow
  task automatic test_table_full();
    write_nodes(2);
    for (int i = 0; i < MaxEdges + 2; i++) send_req(REQ_EDGE, 0, 1, 1'b0);
    send_req(REQ_RUN, 0, 0);
  endtask

  // receiver stops while sender keeps going
  task automatic test_backpressure();
    write_nodes(8);
    hold_rx = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_rx = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_req(REQ_EDGE, i, i + 1, 1'b0);
        send_req(REQ_RUN, 0, 0, 1'b0);
      end
    join
    drain();
  endtask

  task automatic test_random();
    int unsigned n;
    int sent;
    sent = 0;
    while (sent < 170) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10);
      write_nodes(n);
      if ($urandom_range(0, 3) == 0) begin
        // noise: raw random items
        for (int i = 0; i < 8; i++)
          send_req($urandom_range(0, 5) == 0, $urandom_range(0, 31), $urandom_range(0, 31));
        sent += 8;
      end else if (n > 0 && n <= MaxNodes) begin
        dag_and_run(n, $urandom_range(0, 2 * n), $urandom_range(0, 4) == 0);
        sent += n + 3;
      end else begin
        send_req(REQ_RUN, 0, 0);
        sent++;
      end
    end
  endtask

  // output ready: random wait per beat, long hold on request
  initial begin
    int unsigned rx_gap;
    out_ready = 1'b0;
    forever begin
      rx_gap = rx_random ? $urandom_range(0, 11) : 0;
      repeat (rx_gap) @(negedge clk);
      while (hold_rx) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      out_ready = 1'b0;
    end
  end

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    sort_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected beat st=%0d node=%0d last=%0d",
                                      status, node_index, is_last);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (want.st !== status || want.node !== node_index || want.last !== is_last) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch exp st=%0d node=%0d last=%0d got st=%0d node=%0d last=%0d",
                     want.st, want.node, want.last, status, node_index, is_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    mismatches = 0;
    idle_cycles = 0;
    hold_rx = 1'b0;
    rx_random = 1'b1;
    nodes_cfg = 0;
    clear_graph();
    rst = 1'b1;
    cfg_valid = 1'b0;
    node_count = 6'd0;
    in_valid = 1'b0;
    req_type = 1'b0;
    src_node = 5'd0;
    dst_node = 5'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (40) @(negedge clk);
    test_directed();
    test_lowered_count();
    test_table_full();
    test_backpressure();
    test_random();
    write_nodes(32);
    drain();
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

>>> sim.f
design/toe_pkg.sv
design/toe_ram.sv
design/toe_datapath.sv
design/toe_ctrl.sv
design/topological_order_engine_core.sv
bench/tb.sv
